/* hw/rtl/flc_pkg.sv */
// ----------------------------------------------------------------------------
// flc_pkg
// shared constants, register indexes, controller states and the command and
// status bundles of the frame lag correlator
// ----------------------------------------------------------------------------
`default_nettype none

package flc_pkg;

  localparam int MAX_WINDOW    = 16;
  localparam int MAX_FRAME_LEN = 1024;
  localparam int SAMPLE_BITS   = 16;

  localparam int SLOT_W     = $clog2(MAX_WINDOW);
  localparam int POS_W      = $clog2(MAX_FRAME_LEN);
  localparam int ADDR_W     = SLOT_W + POS_W;
  localparam int FS_W       = $clog2(MAX_WINDOW + 1);
  localparam int LEN_W      = 11;
  localparam int LAG_W      = 4;
  localparam int SUM_W      = 42;
  localparam int PROD_W     = 2 * SAMPLE_BITS;
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 11;
  localparam int IN_DATA_W  = ((SAMPLE_BITS + 7) / 8) * 8;
  localparam int OUT_DATA_W = ((SUM_W + LAG_W + 7) / 8) * 8;

  localparam logic [CFG_ADDR_W-1:0] REG_FRAME_LENGTH = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_LOOK_BACK    = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_LOOK_AHEAD   = 2'd2;

  localparam logic [LEN_W-1:0] FRAME_LENGTH_RST = 11'd256;
  localparam logic [LAG_W-1:0] LOOK_BACK_RST    = 4'd1;
  localparam logic [LAG_W-1:0] LOOK_AHEAD_RST   = 4'd0;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD_BASE,
    ST_BASE_WAIT,
    ST_LAG_ISSUE,
    ST_DRAIN,
    ST_DECIDE,
    ST_EMIT,
    ST_FINISH
  } flc_state_t;

  typedef struct packed {
    logic              write;
    logic              rd_base;
    logic              latch_base;
    logic              rd_lag;
    logic              load_out;
    logic              step_pos;
    logic              finish_frame;
    logic [SLOT_W-1:0] idx;
  } flc_cmd_t;

  typedef struct packed {
    logic              accum_en;
    logic              frame_end;
    logic              emit_en;
    logic              pipe_busy;
    logic              out_free;
    logic [SLOT_W-1:0] wm1;
  } flc_status_t;

endpackage

`default_nettype wire

/* hw/rtl/frame_lag_correlator_core.sv */
// ----------------------------------------------------------------------------
// frame_lag_correlator_core
// inter-frame autocorrelation over a sliding window of frames
// ----------------------------------------------------------------------------
// in_* carries one signed Q1.15 sample per transaction; frame_length samples
// make a frame. On the last sample of a frame, once look_ahead frames are in,
// out_* gives W = look_back + look_ahead + 1 transactions: the correlation of
// the oldest window frame with frame oldest+d, the delay d, and tlast on d=W-1.
// Each sample takes one store write; once the window is full it also takes a base
// read, W lag reads through the single read port of the sample store, and a
// drain of the multiply-accumulate pipe. A frame's last sample adds the emission
// of the run, when look_ahead frames are in, and a closing step for the frame.
// The result register lets a new sample be taken while the last result of a run
// still waits; a stalled receiver holds up emission and thereby the next frame
// end. Reset and any write to a mapped register clear the lag sums and the frame
// and sample counters; the sample store is not cleared, its stale entries are
// never read into a result. Configuration must be written over cfg_* only while
// the block is idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
`default_nettype none

module frame_lag_correlator_core (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                cfg_we,
  input  wire logic [flc_pkg::CFG_ADDR_W-1:0]      cfg_addr,
  input  wire logic [flc_pkg::CFG_DATA_W-1:0]      cfg_wdata,
  input  wire logic                                in_tvalid,
  output logic                                     in_tready,
  input  wire logic [flc_pkg::IN_DATA_W-1:0]       in_tdata,   // sample
  output logic                                     out_tvalid,
  input  wire logic                                out_tready,
  output logic      [flc_pkg::OUT_DATA_W-1:0]      out_tdata,  // correlation, delay_index
  output logic                                     out_tlast   // last_of_run
);

  flc_pkg::flc_cmd_t              cmd;
  flc_pkg::flc_status_t           status;
  logic [flc_pkg::SUM_W-1:0]      correlation;
  logic [flc_pkg::LAG_W-1:0]      delay_index;

  flc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .status    (status),
    .cmd       (cmd)
  );

  flc_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_addr        (cfg_addr),
    .cfg_wdata       (cfg_wdata),
    .in_sample       (in_tdata[flc_pkg::SAMPLE_BITS-1:0]),
    .cmd             (cmd),
    .status          (status),
    .out_tvalid      (out_tvalid),
    .out_tready      (out_tready),
    .out_correlation (correlation),
    .out_delay_index (delay_index),
    .out_last        (out_tlast)
  );

  assign out_tdata = {(flc_pkg::OUT_DATA_W-flc_pkg::SUM_W-flc_pkg::LAG_W)'(0),
                      delay_index, correlation};

  a_load_into_free_slot: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> (!out_tvalid || out_tready))
    else $error("result loaded over a pending transaction");

  a_no_accept_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |-> (!cmd.rd_lag && !cmd.load_out && !status.pipe_busy))
    else $error("sample taken while a frame run is in progress");

  a_finish_returns_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish_frame |=> in_tready)
    else $error("controller did not return to idle after frame close");

endmodule

`default_nettype wire

/* hw/rtl/flc_ram.sv */
// ----------------------------------------------------------------------------
// flc_ram
// generic single write port, single read port ram with registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module flc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

/* hw/rtl/flc_ctrl.sv */
// ----------------------------------------------------------------------------
// flc_ctrl
// sequencer: takes a sample, walks the lag reads, drains the mac pipe and
// hands out at most one run of correlations per frame
// ----------------------------------------------------------------------------
`default_nettype none

module flc_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_tvalid,
  output logic                      in_tready,
  input  wire flc_pkg::flc_status_t status,
  output flc_pkg::flc_cmd_t         cmd
);

  flc_pkg::flc_state_t             state_r, state_nxt;
  logic [flc_pkg::SLOT_W-1:0]      idx_r, idx_nxt;

  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    unique case (state_r)
      flc_pkg::ST_IDLE: begin
        if (in_tvalid) begin
          state_nxt = status.accum_en ? flc_pkg::ST_RD_BASE : flc_pkg::ST_DECIDE;
        end
      end
      flc_pkg::ST_RD_BASE: begin
        state_nxt = flc_pkg::ST_BASE_WAIT;
      end
      flc_pkg::ST_BASE_WAIT: begin
        idx_nxt   = '0;
        state_nxt = flc_pkg::ST_LAG_ISSUE;
      end
      flc_pkg::ST_LAG_ISSUE: begin
        idx_nxt = idx_r + 1'b1;
        if (idx_r == status.wm1) begin
          state_nxt = flc_pkg::ST_DRAIN;
        end
      end
      flc_pkg::ST_DRAIN: begin
        if (!status.pipe_busy) begin
          state_nxt = flc_pkg::ST_DECIDE;
        end
      end
      flc_pkg::ST_DECIDE: begin
        idx_nxt = '0;
        if (!status.frame_end) begin
          state_nxt = flc_pkg::ST_IDLE;
        end else if (status.emit_en) begin
          state_nxt = flc_pkg::ST_EMIT;
        end else begin
          state_nxt = flc_pkg::ST_FINISH;
        end
      end
      flc_pkg::ST_EMIT: begin
        if (status.out_free) begin
          idx_nxt = idx_r + 1'b1;
          if (idx_r == status.wm1) begin
            state_nxt = flc_pkg::ST_FINISH;
          end
        end
      end
      flc_pkg::ST_FINISH: begin
        state_nxt = flc_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = flc_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd       = '0;
    cmd.idx   = idx_r;
    in_tready = 1'b0;
    unique case (state_r)
      flc_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        cmd.write = in_tvalid;
      end
      flc_pkg::ST_RD_BASE:   cmd.rd_base    = 1'b1;
      flc_pkg::ST_BASE_WAIT: cmd.latch_base = 1'b1;
      flc_pkg::ST_LAG_ISSUE: cmd.rd_lag     = 1'b1;
      flc_pkg::ST_DRAIN: begin
      end
      flc_pkg::ST_DECIDE:    cmd.step_pos   = !status.frame_end;
      flc_pkg::ST_EMIT:      cmd.load_out   = status.out_free;
      flc_pkg::ST_FINISH:    cmd.finish_frame = 1'b1;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= flc_pkg::ST_IDLE;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/flc_dp.sv */
// ----------------------------------------------------------------------------
// flc_dp
// datapath: configuration registers, frame counters, sample store, one
// multiply-accumulate pipe over the lag sums and the result register
// ----------------------------------------------------------------------------
`default_nettype none

module flc_dp (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             cfg_we,
  input  wire logic [flc_pkg::CFG_ADDR_W-1:0]   cfg_addr,
  input  wire logic [flc_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  input  wire logic [flc_pkg::SAMPLE_BITS-1:0]  in_sample,
  input  wire flc_pkg::flc_cmd_t                cmd,
  output flc_pkg::flc_status_t                  status,
  output logic                                  out_tvalid,
  input  wire logic                             out_tready,
  output logic      [flc_pkg::SUM_W-1:0]        out_correlation,
  output logic      [flc_pkg::LAG_W-1:0]        out_delay_index,
  output logic                                  out_last
);

  localparam int SLOT_W = flc_pkg::SLOT_W;
  localparam int POS_W  = flc_pkg::POS_W;
  localparam int SUM_W  = flc_pkg::SUM_W;
  localparam int PROD_W = flc_pkg::PROD_W;
  localparam int SB     = flc_pkg::SAMPLE_BITS;

  logic [flc_pkg::LEN_W-1:0] frame_length_r;
  logic [flc_pkg::LAG_W-1:0] look_back_r;
  logic [flc_pkg::LAG_W-1:0] look_ahead_r;

  logic [POS_W-1:0]        pos_r;
  logic [SLOT_W-1:0]       slot_r;
  logic [flc_pkg::FS_W-1:0] frames_seen_r;

  logic [SUM_W-1:0]        psum_r [flc_pkg::MAX_WINDOW];
  logic [SB-1:0]           base_r;
  logic                    v1_r, v2_r;
  logic [SLOT_W-1:0]       d1_r, d2_r;
  logic [PROD_W-1:0]       prod_r;

  logic                    out_valid_r;
  logic [SUM_W-1:0]        out_corr_r;
  logic [flc_pkg::LAG_W-1:0] out_delay_r;
  logic                    out_last_r;

  logic [SLOT_W-1:0]       lb_eff, la_eff, room, wm1, oldest, rd_slot;
  logic [POS_W:0]          len_eff;
  logic [flc_pkg::ADDR_W-1:0] waddr, raddr;
  logic [SB-1:0]           ram_rdata;
  logic                    cfg_hit;
  logic                    clear_run;
  logic                    out_free;

  // effective window and frame length
  always_comb begin
    if (32'(look_back_r) > flc_pkg::MAX_WINDOW - 1) begin
      lb_eff = SLOT_W'(flc_pkg::MAX_WINDOW - 1);
    end else begin
      lb_eff = SLOT_W'(look_back_r);
    end
    room = SLOT_W'(flc_pkg::MAX_WINDOW - 1) - lb_eff;
    if (32'(look_ahead_r) > 32'(room)) begin
      la_eff = room;
    end else begin
      la_eff = SLOT_W'(look_ahead_r);
    end
    wm1 = lb_eff + la_eff;
    if (frame_length_r == '0) begin
      len_eff = (POS_W+1)'(1);
    end else if (32'(frame_length_r) > flc_pkg::MAX_FRAME_LEN) begin
      len_eff = (POS_W+1)'(flc_pkg::MAX_FRAME_LEN);
    end else begin
      len_eff = (POS_W+1)'(frame_length_r);
    end
  end

  assign oldest   = slot_r - wm1;
  assign rd_slot  = cmd.rd_base ? oldest : oldest + cmd.idx;
  assign waddr    = {slot_r, pos_r};
  assign raddr    = {rd_slot, pos_r};
  assign out_free = !out_valid_r || out_tready;

  always_comb begin
    status.accum_en  = frames_seen_r >= flc_pkg::FS_W'(wm1);
    status.emit_en   = frames_seen_r >= flc_pkg::FS_W'(la_eff);
    status.frame_end = ((POS_W+1)'(pos_r) + 1'b1) >= len_eff;
    status.pipe_busy = v1_r || v2_r;
    status.out_free  = out_free;
    status.wm1       = wm1;
  end

  flc_ram #(
    .WIDTH (SB),
    .DEPTH (flc_pkg::MAX_WINDOW * flc_pkg::MAX_FRAME_LEN)
  ) u_store (
    .clk   (clk),
    .we    (cmd.write),
    .waddr (waddr),
    .wdata (in_sample),
    .raddr (raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    cfg_hit = 1'b0;
    if (cfg_we) begin
      unique case (cfg_addr)
        flc_pkg::REG_FRAME_LENGTH,
        flc_pkg::REG_LOOK_BACK,
        flc_pkg::REG_LOOK_AHEAD: cfg_hit = 1'b1;
        default:                 cfg_hit = 1'b0;
      endcase
    end
  end

  assign clear_run = cfg_hit || cmd.finish_frame;

  // configuration and frame counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_length_r <= flc_pkg::FRAME_LENGTH_RST;
      look_back_r    <= flc_pkg::LOOK_BACK_RST;
      look_ahead_r   <= flc_pkg::LOOK_AHEAD_RST;
      pos_r          <= '0;
      slot_r         <= '0;
      frames_seen_r  <= '0;
    end else begin
      if (cfg_hit) begin
        unique case (cfg_addr)
          flc_pkg::REG_FRAME_LENGTH: frame_length_r <= cfg_wdata;
          flc_pkg::REG_LOOK_BACK:    look_back_r    <= flc_pkg::LAG_W'(cfg_wdata);
          flc_pkg::REG_LOOK_AHEAD:   look_ahead_r   <= flc_pkg::LAG_W'(cfg_wdata);
          default: begin
          end
        endcase
        pos_r         <= '0;
        slot_r        <= '0;
        frames_seen_r <= '0;
      end else if (cmd.finish_frame) begin
        pos_r  <= '0;
        slot_r <= slot_r + 1'b1;
        if (32'(frames_seen_r) < flc_pkg::MAX_WINDOW) begin
          frames_seen_r <= frames_seen_r + 1'b1;
        end
      end else if (cmd.step_pos) begin
        pos_r <= pos_r + 1'b1;
      end
    end
  end

  // mac pipe: read tag, product, accumulate
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= cmd.rd_lag;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    d1_r   <= cmd.idx;
    d2_r   <= d1_r;
    prod_r <= PROD_W'($signed(base_r) * $signed(ram_rdata));
    if (cmd.latch_base) begin
      base_r <= ram_rdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || clear_run) begin
      for (int i = 0; i < flc_pkg::MAX_WINDOW; i++) begin
        psum_r[i] <= '0;
      end
    end else if (v2_r) begin
      psum_r[d2_r] <= psum_r[d2_r] + {{(SUM_W-PROD_W){prod_r[PROD_W-1]}}, prod_r};
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_corr_r  <= psum_r[cmd.idx];
      out_delay_r <= flc_pkg::LAG_W'(cmd.idx);
      out_last_r  <= cmd.idx == wm1;
    end
  end

  assign out_tvalid      = out_valid_r;
  assign out_correlation = out_corr_r;
  assign out_delay_index = out_delay_r;
  assign out_last        = out_last_r;

endmodule

`default_nettype wire

/* bench/tb_frame_lag_correlator_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_frame_lag_correlator_core
// self-checking bench for the inter-frame lag correlator
// ----------------------------------------------------------------------------
// A directed plan comes first. It covers the reset look-back and look-ahead
// values, a frame length of zero, full-scale samples, a window larger than
// the store, and a write to an unmapped register index. Random
// register settings follow, each fed whole frames of random samples, sometimes
// with a trailing partial frame. Every accepted sample updates a local model of
// the window store and the lag sums. Each correlation transaction is checked
// field by field against the oldest pending expectation. Both stream sides idle
// at random, with one stretch that runs without gaps.
// ----------------------------------------------------------------------------

module tb_frame_lag_correlator_core;
  import flc_pkg::*;

  localparam int RANDOM_ITEMS  = 195;
  localparam int SETTLE_CYCLES = 64;
  localparam int CYCLE_LIMIT   = 400000;

  localparam logic [CFG_ADDR_W-1:0] REG_UNMAPPED = 2'd3;

  typedef struct packed {
    logic [SUM_W-1:0] corr;
    logic [LAG_W-1:0] delay;
    logic             last;
  } lag_result_t;

  typedef enum logic {ROW_CFG, ROW_SAMPLE} row_kind_t;

  typedef struct packed {
    row_kind_t             kind;
    logic [CFG_ADDR_W-1:0] addr;
    logic [CFG_DATA_W-1:0] value;
    logic [15:0]           sample;
    logic [10:0]           reps;
    logic                  pinned;
    logic [SUM_W-1:0]      corr;
  } plan_row_t;

  localparam int PLAN_ROWS = 23;
  localparam plan_row_t PLAN [PLAN_ROWS] = '{
    '{ROW_CFG,    REG_FRAME_LENGTH, 11'd1,    16'h0000, 11'd0,    1'b0, 42'd0},
    '{ROW_SAMPLE, REG_FRAME_LENGTH, 11'd0,    16'h7FFF, 11'd1,    1'b1, 42'd0},
    '{ROW_CFG,    REG_FRAME_LENGTH, 11'd0,    16'h0000, 11'd0,    1'b0, 42'd0},
    '{ROW_CFG,    REG_LOOK_BACK,    11'd0,    16'h0000, 11'd0,    1'b0, 42'd0},
    '{ROW_CFG,    REG_LOOK_AHEAD,   11'd0,    16'h0000, 11'd0,    1'b0, 42'd0},
    '{ROW_SAMPLE, REG_FRAME_LENGTH, 11'd0,    16'h8000, 11'd1,    1'b1, 42'd1073741824},
    '{ROW_SAMPLE, REG_FRAME_LENGTH, 11'd0,    16'h7FFF, 11'd1,    1'b1, 42'd1073676289},
    '{ROW_SAMPLE, REG_FRAME_LENGTH, 11'd0,    16'h0000, 11'd1,    1'b1, 42'd0},
    '{ROW_SAMPLE, REG_FRAME_LENGTH, 11'd0,    16'hFFFF, 11'd1,    1'b1, 42'd1},
    '{ROW_CFG,    REG_FRAME_LENGTH, 11'd3,    16'h0000, 11'd0,    1'b0, 42'd0},
    '{ROW_CFG,    REG_LOOK_BACK,    11'd2,    16'h0000, 11'd0,    1'b0, 42'd0},
    '{ROW_CFG,    REG_LOOK_AHEAD,   11'd1,    16'h0000, 11'd0,    1'b0, 42'd0},
    '{ROW_SAMPLE, REG_FRAME_LENGTH, 11'd0,    16'h1234, 11'd3,    1'b0, 42'd0},
    '{ROW_SAMPLE, REG_FRAME_LENGTH, 11'd0,    16'h8000, 11'd6,    1'b1, 42'd0},
    '{ROW_SAMPLE, REG_FRAME_LENGTH, 11'd0,    16'h7FFF, 11'd3,    1'b0, 42'd0},
    '{ROW_CFG,    REG_UNMAPPED,     11'h7FF,  16'h0000, 11'd0,    1'b0, 42'd0},
    '{ROW_SAMPLE, REG_FRAME_LENGTH, 11'd0,    16'h5A5A, 11'd2,    1'b0, 42'd0},
    '{ROW_SAMPLE, REG_FRAME_LENGTH, 11'd0,    16'hA5A5, 11'd1,    1'b0, 42'd0},
    '{ROW_CFG,    REG_LOOK_BACK,    11'd15,   16'h0000, 11'd0,    1'b0, 42'd0},
    '{ROW_CFG,    REG_LOOK_AHEAD,   11'd15,   16'h0000, 11'd0,    1'b0, 42'd0},
    '{ROW_CFG,    REG_FRAME_LENGTH, 11'd1,    16'h0000, 11'd0,    1'b0, 42'd0},
    '{ROW_SAMPLE, REG_FRAME_LENGTH, 11'd0,    16'h4000, 11'd15,   1'b1, 42'd0},
    '{ROW_SAMPLE, REG_FRAME_LENGTH, 11'd0,    16'hC000, 11'd2,    1'b0, 42'd0}
  };

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;    // sample
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;        // correlation, delay_index
  logic                  out_tlast;        // last_of_run

  frame_lag_correlator_core DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  always #1 clk = ~clk;

  // local copy of the block state
  logic [LEN_W-1:0]        frame_len_reg = FRAME_LENGTH_RST;
  logic [LAG_W-1:0]        back_reg = LOOK_BACK_RST;
  logic [LAG_W-1:0]        ahead_reg = LOOK_AHEAD_RST;
  logic signed [15:0]      frame_history [MAX_WINDOW][MAX_FRAME_LEN];
  logic [SUM_W-1:0]        lag_sums [MAX_WINDOW];
  int                      sample_pos = 0;
  int                      frames_seen = 0;
  int                      frame_slot = 0;

  lag_result_t             pending_corr [$];
  bit                      steady = 1'b0;
  int                      err_count = 0;
  int                      results_checked = 0;
  int                      samples_sent = 0;
  int                      cycle_count = 0;

  function automatic int back_eff();
    return (int'(back_reg) > MAX_WINDOW - 1) ? MAX_WINDOW - 1 : int'(back_reg);
  endfunction

  function automatic int ahead_eff();
    int room;
    room = MAX_WINDOW - 1 - back_eff();
    return (int'(ahead_reg) > room) ? room : int'(ahead_reg);
  endfunction

  function automatic int len_eff();
    if (frame_len_reg == 0) return 1;
    if (int'(frame_len_reg) > MAX_FRAME_LEN) return MAX_FRAME_LEN;
    return int'(frame_len_reg);
  endfunction

  function automatic void restart_frames();
    int d;
    for (d = 0; d < MAX_WINDOW; d++) lag_sums[d] = '0;
    sample_pos = 0;
    frames_seen = 0;
    frame_slot = 0;
  endfunction

  function automatic void apply_register(logic [CFG_ADDR_W-1:0] idx,
                                         logic [CFG_DATA_W-1:0] val);
    case (idx)
      REG_FRAME_LENGTH: frame_len_reg = val[LEN_W-1:0];
      REG_LOOK_BACK:    back_reg = val[LAG_W-1:0];
      REG_LOOK_AHEAD:   ahead_reg = val[LAG_W-1:0];
      default:          return;
    endcase
    restart_frames();
  endfunction

  // store the sample, accumulate lag products, queue a run at frame end once enough frames are in
  function automatic void correlate_sample(logic [15:0] raw, logic pinned,
                                           logic [SUM_W-1:0] pinned_corr);
    int                 span;
    int                 oldest;
    int                 d;
    logic signed [15:0] base;
    logic signed [31:0] prod;
    lag_result_t        r;
    span = back_eff() + ahead_eff() + 1;
    oldest = (frame_slot + MAX_WINDOW - (span - 1)) % MAX_WINDOW;
    frame_history[frame_slot][sample_pos] = raw;
    if (frames_seen >= span - 1) begin
      base = frame_history[oldest][sample_pos];
      for (d = 0; d < span; d++) begin
        prod = base * frame_history[(oldest + d) % MAX_WINDOW][sample_pos];
        lag_sums[d] = lag_sums[d] + {{(SUM_W - 32){prod[31]}}, prod};
      end
    end
    if (sample_pos + 1 >= len_eff()) begin
      if (frames_seen >= ahead_eff()) begin
        for (d = 0; d < span; d++) begin
          r.corr  = (frames_seen >= span - 1) ? lag_sums[d] : '0;
          if (pinned) r.corr = pinned_corr;
          r.delay = d[LAG_W-1:0];
          r.last  = (d == span - 1);
          pending_corr.push_back(r);
        end
      end
      for (d = 0; d < MAX_WINDOW; d++) lag_sums[d] = '0;
      sample_pos = 0;
      frame_slot = (frame_slot + 1) % MAX_WINDOW;
      if (frames_seen < MAX_WINDOW) frames_seen++;
    end else begin
      sample_pos++;
    end
  endfunction

  function automatic logic [15:0] pick_sample();
    case ($urandom_range(7))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send_sample(logic [15:0] s, logic pinned, logic [SUM_W-1:0] pinned_corr);
    while (!steady && $urandom_range(99) < 27) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= s;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    correlate_sample(s, pinned, pinned_corr);
    samples_sent++;
  endtask

  // cfg_we stays high across back-to-back writes; the caller lowers it
  task automatic write_register(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    apply_register(idx, val);
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (pending_corr.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  always @(posedge clk) begin : result_check
    lag_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_corr.size() == 0) begin
        $error("unexpected transaction: correlation %0d, delay_index %0d",
               $signed(out_tdata[SUM_W-1:0]), out_tdata[SUM_W +: LAG_W]);
        err_count++;
      end else begin
        want = pending_corr.pop_front();
        results_checked++;
        if (out_tdata[SUM_W-1:0] !== want.corr) begin
          $error("correlation: expected %0d, got %0d",
                 $signed(want.corr), $signed(out_tdata[SUM_W-1:0]));
          err_count++;
        end
        if (out_tdata[SUM_W +: LAG_W] !== want.delay) begin
          $error("delay_index: expected %0d, got %0d", want.delay, out_tdata[SUM_W +: LAG_W]);
          err_count++;
        end
        if (out_tlast !== want.last) begin
          $error("last_of_run: expected %0b, got %0b", want.last, out_tlast);
          err_count++;
        end
      end
    end
    out_tready <= steady || ($urandom_range(99) >= 27);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb_frame_lag_correlator_core: errors");
      $finish;
    end
  end

  initial begin
    int row;
    int n;
    int lb;
    int la;
    int span;
    int len;
    int count;
    int random_items;
    int phase_count;
    bit dirty;
    dirty = 1'b0;
    random_items = 0;
    phase_count = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    for (row = 0; row < PLAN_ROWS; row++) begin
      if (PLAN[row].kind == ROW_CFG) begin
        if (dirty) drain_results();
        dirty = 1'b0;
        write_register(PLAN[row].addr, PLAN[row].value);
      end else begin
        cfg_we <= 1'b0;
        for (n = 0; n < int'(PLAN[row].reps); n++)
          send_sample(PLAN[row].sample, PLAN[row].pinned, PLAN[row].corr);
        dirty = 1'b1;
      end
    end

    while (random_items < RANDOM_ITEMS) begin
      drain_results();
      steady = (phase_count == 2);
      lb = $urandom_range(0, $urandom_range(0, 1) ? 3 : 15);
      la = $urandom_range(0, $urandom_range(0, 1) ? 3 : 15);
      write_register(REG_LOOK_BACK, {7'($urandom), 4'(lb)});
      write_register(REG_LOOK_AHEAD, {7'($urandom), 4'(la)});
      span = back_eff() + ahead_eff() + 1;
      len = (span > 8) ? $urandom_range(1, 2) : $urandom_range(1, 8);
      write_register(REG_FRAME_LENGTH, 11'(len));
      cfg_we <= 1'b0;
      // whole frames past the fill, sometimes a trailing partial frame
      count = (span + $urandom_range(0, 3)) * len;
      if ($urandom_range(0, 1)) count += $urandom_range(0, len - 1);
      repeat (count) begin
        send_sample(pick_sample(), 1'b0, '0);
        random_items++;
      end
      phase_count++;
    end
    steady = 1'b0;
    drain_results();

    $display("run covered %0d samples over %0d random register settings plus the plan,",
             samples_sent, phase_count);
    $display("with %0d correlation transactions compared", results_checked);
    if (err_count == 0) begin
      $display("tb_frame_lag_correlator_core: clean");
    end else begin
      $display("tb_frame_lag_correlator_core: errors");
    end
    $finish;
  end

endmodule
